// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/scqde_pkg.sv =====
// ----------------------------------------------------------------------------
// scqde_pkg
// types and constants of the sparse coefficient quantizer and delta encoder
// ----------------------------------------------------------------------------
package scqde_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_SHIFT   = 2'd0;
  localparam kind_t KIND_ENTRY   = 2'd1;
  localparam kind_t KIND_COL_END = 2'd2;
  localparam kind_t KIND_RSVD    = 2'd3;

  localparam kind_t REC_SHIFT = 2'd0;
  localparam kind_t REC_COEFF = 2'd1;
  localparam kind_t REC_FILL  = 2'd2;

  localparam int VALUE_W     = 32;
  localparam int ROW_W       = 16;
  localparam int COL_W       = 16;
  localparam int IDX_W       = 20;
  localparam int DELTA_W     = 16;
  localparam int LEVEL_W     = 8;
  localparam int STEP_W      = 17;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - DELTA_W - LEVEL_W - VALUE_W;

  localparam int DIV_W     = 31;
  localparam int DIV_CNT_W = 5;

  localparam int STEP_BASE   = 4000;
  localparam int SHIFT_INIT  = 127;
  localparam int DEQ_DIVISOR = 25;
  localparam int DEQ_BIAS    = 12;
  localparam int DEQ_SHIFT   = 6;

endpackage

// ===== src/sparse_coeff_quant_delta_encoder_core.sv =====
// ----------------------------------------------------------------------------
// sparse_coeff_quant_delta_encoder_core
// quantizes and delta-encodes sparse matrix entries and shift samples
// ----------------------------------------------------------------------------
// input stream: s_tuser_i carries the item kind (shift, entry, column end),
// s_tdata_i the value, row and column. output stream: m_tuser_o carries the
// record kind, m_tdata_o the index, position delta, level and rebuilt value.
// row_count is written through cfg_we_i / cfg_wdata_i; the user must do so
// only while the block idles, which the block does not enforce. one item is
// processed at a time; s_tready_o is high while idle. shift samples and fill
// records pass through the prep and emit states, and emit loads the output
// register; a column end that emits nothing returns to idle from prep. a
// matrix entry runs two passes of a shared radix-2 divider, 31 quotient bits
// each (quantize, then dequantize); an entry that quantizes to zero ends
// after the first pass. results go to an output register, so a new item is
// taken while the last result still waits; if the receiver still stalls when
// the next result is finished, that result holds in the block until the
// output register frees. reset clears the control state: row_count 1,
// previous shift 127, counters and last position 0, output empty.
// ----------------------------------------------------------------------------
module sparse_coeff_quant_delta_encoder_core #(
  parameter int POSITION_WIDTH = 32,
  parameter int COUNT_WIDTH    = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [scqde_pkg::ROW_W-1:0]        cfg_wdata_i,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // value, row, column
  input  logic [scqde_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  // kind
  input  scqde_pkg::kind_t                   s_tuser_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // index, position_delta, level, rebuilt_value, zero pad
  output logic [scqde_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  // record_kind
  output scqde_pkg::kind_t                   m_tuser_o
);

  import scqde_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_DEQ  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [ROW_W-1:0]          rc_q, rc_d;
  logic [LEVEL_W-1:0]        prev_q, prev_d;
  logic [POSITION_WIDTH-1:0] last_q, last_d;
  logic                      colem_q, colem_d;
  logic [COUNT_WIDTH-1:0]    scnt_q, scnt_d;
  logic [COUNT_WIDTH-1:0]    rcnt_q, rcnt_d;
  logic [DIV_CNT_W-1:0]      cnt_q, cnt_d;
  logic                      m_valid_q, m_valid_d;

  kind_t                     in_kind_q, in_kind_d;
  logic [VALUE_W-1:0]        val_q, val_d;
  logic [ROW_W-1:0]          row_q, row_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic [DIV_W-1:0]          dq_q, dq_d;
  logic [STEP_W-1:0]         rem_q, rem_d;
  logic [STEP_W-1:0]         dvs_q, dvs_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  kind_t                     res_kind_q, res_kind_d;
  logic [LEVEL_W-1:0]        res_level_q, res_level_d;
  logic [VALUE_W-1:0]        res_reb_q, res_reb_d;
  kind_t                     m_kind_q, m_kind_d;
  logic [IDX_W-1:0]          m_index_q, m_index_d;
  logic [DELTA_W-1:0]        m_delta_q, m_delta_d;
  logic [LEVEL_W-1:0]        m_level_q, m_level_d;
  logic [VALUE_W-1:0]        m_reb_q, m_reb_d;

  logic                      in_xfer;
  logic                      out_free;
  logic                      neg;
  logic [VALUE_W-1:0]        mag;
  logic [23:0]               sh_q;
  logic [LEVEL_W-1:0]        sh_low;
  logic [VALUE_W-1:0]        sh_mag;
  logic [VALUE_W-1:0]        sh_reb;
  logic [STEP_W-1:0]         step;
  logic [39:0]               num;
  logic [STEP_W-1:0]         mul_a;
  logic [32:0]               prod;
  logic [33:0]               pos_sum;
  logic [STEP_W+1:0]         trial;
  logic                      qbit;
  logic [LEVEL_W-1:0]        lmag;
  logic [24:0]               xmul;

  assign in_xfer    = s_tvalid_i && s_tready_o;
  assign out_free   = !m_valid_q || m_tready_i;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_valid_q;
  assign m_tuser_o  = m_kind_q;
  assign m_tdata_o  = {{OUT_PAD_W{1'b0}}, m_reb_q, m_level_q, m_delta_q, m_index_q};

  // operand forms shared by the states
  always_comb begin
    neg     = val_q[VALUE_W-1];
    mag     = neg ? (~val_q + 32'd1) : val_q;
    sh_q    = 24'((33'(mag) + 33'd128) >> 8);
    sh_low  = neg ? (8'd0 - sh_q[7:0]) : sh_q[7:0];
    sh_mag  = {sh_q, 8'd0};
    sh_reb  = (!neg && sh_q[23]) ? 32'h7fff_ffff : (neg ? (32'd0 - sh_mag) : sh_mag);
    step    = STEP_W'(STEP_BASE) + STEP_W'(row_q);
    num     = (40'(mag) << 6) + (40'(mag) << 5) + (40'(mag) << 2) + (40'(step) << 7);
    mul_a   = (in_kind_q == KIND_COL_END) ? (STEP_W'(col_q) + 17'd1) : STEP_W'(col_q);
    prod    = 33'(mul_a) * 33'(rc_q);
    pos_sum = 34'(prod) + ((in_kind_q == KIND_ENTRY) ? 34'(row_q) : 34'd0);
    trial   = {1'b0, rem_q, dq_q[DIV_W-1]} - {2'b00, dvs_q};
    qbit    = !trial[STEP_W+1];
    if (neg) begin
      lmag = (dq_q > DIV_W'(128)) ? 8'd128 : dq_q[LEVEL_W-1:0];
    end else begin
      lmag = (dq_q > DIV_W'(127)) ? 8'd127 : dq_q[LEVEL_W-1:0];
    end
    xmul = 25'(lmag) * 25'(step);
  end

  always_comb begin
    state_d     = state_q;
    rc_d        = cfg_we_i ? cfg_wdata_i : rc_q;
    prev_d      = prev_q;
    last_d      = last_q;
    colem_d     = colem_q;
    scnt_d      = scnt_q;
    rcnt_d      = rcnt_q;
    cnt_d       = cnt_q;
    m_valid_d   = m_valid_q && !m_tready_i;
    in_kind_d   = in_kind_q;
    val_d       = val_q;
    row_d       = row_q;
    col_d       = col_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    pos_d       = pos_q;
    res_kind_d  = res_kind_q;
    res_level_d = res_level_q;
    res_reb_d   = res_reb_q;
    m_kind_d    = m_kind_q;
    m_index_d   = m_index_q;
    m_delta_d   = m_delta_q;
    m_level_d   = m_level_q;
    m_reb_d     = m_reb_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          in_kind_d = s_tuser_i;
          val_d     = s_tdata_i[VALUE_W-1:0];
          row_d     = s_tdata_i[VALUE_W+ROW_W-1:VALUE_W];
          col_d     = s_tdata_i[IN_TDATA_W-1:VALUE_W+ROW_W];
          if (s_tuser_i != KIND_RSVD) begin
            state_d = S_PREP;
          end
        end
      end
      S_PREP: begin
        pos_d = POSITION_WIDTH'(pos_sum);
        case (in_kind_q)
          KIND_SHIFT: begin
            res_kind_d  = REC_SHIFT;
            res_level_d = sh_low - prev_q;
            res_reb_d   = sh_reb;
            state_d     = S_EMIT;
          end
          KIND_ENTRY: begin
            dq_d    = DIV_W'(num >> 8);
            rem_d   = '0;
            dvs_d   = step;
            cnt_d   = DIV_CNT_W'(DIV_W - 1);
            state_d = S_DIV1;
          end
          KIND_COL_END: begin
            if (colem_q) begin
              colem_d = 1'b0;
              state_d = S_IDLE;
            end else begin
              res_kind_d  = REC_FILL;
              res_level_d = '0;
              res_reb_d   = '0;
              state_d     = S_EMIT;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DIV1, S_DIV2: begin
        rem_d = qbit ? trial[STEP_W-1:0] : STEP_W'({rem_q, dq_q[DIV_W-1]});
        dq_d  = {dq_q[DIV_W-2:0], qbit};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          state_d = (state_q == S_DIV1) ? S_DEQ : S_EMIT;
        end
      end
      S_DEQ: begin
        if (lmag == '0) begin
          state_d = S_IDLE;
        end else begin
          res_kind_d  = REC_COEFF;
          res_level_d = neg ? (8'd0 - lmag) : lmag;
          // rebuilt magnitude = floor((64 * |level| * step + 12) / 25)
          dq_d        = (DIV_W'(xmul) << DEQ_SHIFT) + DIV_W'(DEQ_BIAS);
          rem_d       = '0;
          dvs_d       = STEP_W'(DEQ_DIVISOR);
          cnt_d       = DIV_CNT_W'(DIV_W - 1);
          state_d     = S_DIV2;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_kind_d  = res_kind_q;
          m_level_d = res_level_q;
          if (res_kind_q == REC_SHIFT) begin
            m_index_d = IDX_W'(scnt_q);
            m_delta_d = '0;
            m_reb_d   = res_reb_q;
            prev_d    = prev_q + res_level_q;
            scnt_d    = scnt_q + 1'b1;
          end else begin
            m_index_d = IDX_W'(rcnt_q);
            m_delta_d = DELTA_W'(pos_q - last_q);
            m_reb_d   = (res_kind_q == REC_COEFF)
                        ? (neg ? (32'd0 - 32'(dq_q)) : 32'(dq_q)) : res_reb_q;
            last_d    = pos_q;
            rcnt_d    = rcnt_q + 1'b1;
            if (res_kind_q == REC_COEFF) begin
              colem_d = 1'b1;
            end
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rc_q      <= 16'd1;
      prev_q    <= LEVEL_W'(SHIFT_INIT);
      last_q    <= '0;
      colem_q   <= 1'b0;
      scnt_q    <= '0;
      rcnt_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rc_q      <= rc_d;
      prev_q    <= prev_d;
      last_q    <= last_d;
      colem_q   <= colem_d;
      scnt_q    <= scnt_d;
      rcnt_q    <= rcnt_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_kind_q   <= in_kind_d;
    val_q       <= val_d;
    row_q       <= row_d;
    col_q       <= col_d;
    dq_q        <= dq_d;
    rem_q       <= rem_d;
    dvs_q       <= dvs_d;
    pos_q       <= pos_d;
    res_kind_q  <= res_kind_d;
    res_level_q <= res_level_d;
    res_reb_q   <= res_reb_d;
    m_kind_q    <= m_kind_d;
    m_index_q   <= m_index_d;
    m_delta_q   <= m_delta_d;
    m_level_q   <= m_level_d;
    m_reb_q     <= m_reb_d;
  end

`include "assert_macros.svh"

  `ASSERT_ON(a_xfer_to_prep, (in_xfer && s_tuser_i != KIND_RSVD) |=> (state_q == S_PREP), "item transfer did not start processing")
  `ASSERT_ON(a_deq_divisor, (state_q == S_DIV2) |-> (dvs_q == STEP_W'(DEQ_DIVISOR)), "dequantize pass with wrong divisor")
  `ASSERT_ON(a_coeff_nonzero, (m_valid_q && m_kind_q == REC_COEFF) |-> (m_level_q != '0), "coefficient record with zero level")
  `ASSERT_ALWAYS(a_fill_zero, (m_valid_q && m_kind_q == REC_FILL) |-> (m_level_q == '0 && m_reb_q == '0), "fill record with nonzero payload")

endmodule
